[rtl/ebj_pkg.sv]
package ebj_pkg;

	localparam int DELAY_BITS = 32;
	localparam int RND_BITS   = 32;
	localparam int DVS_BITS   = DELAY_BITS + 1;
	localparam int OUT_BITS   = DELAY_BITS + 1;
	localparam int CNT_BITS   = $clog2(RND_BITS);

	localparam logic CMD_NEXT  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} ebj_state_t;

	typedef struct packed {
		logic start;
	} ebj_mod_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ebj_mod_sts_t;

endpackage

[rtl/ebj_mod.sv]
module ebj_mod import ebj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ebj_mod_ctl_t         ctl,
	input  logic [RND_BITS-1:0]  dividend,
	input  logic [DVS_BITS-1:0]  divisor,
	output ebj_mod_sts_t         sts,
	output logic [DVS_BITS-1:0]  remainder
);

	logic [DVS_BITS-1:0] rem_q;
	logic [RND_BITS-1:0] dvd_q;
	logic [DVS_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DVS_BITS:0]   trial;
	logic [DVS_BITS:0]   diff;
	logic [DVS_BITS-1:0] rem_nxt;

	// one restoring step per cycle, MSB first
	always_comb begin
		trial = {rem_q, dvd_q[RND_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = diff[DVS_BITS-1:0];
		end else begin
			rem_nxt = trial[DVS_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(RND_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[RND_BITS-2:0], 1'b0};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign remainder = rem_q;

endmodule

[rtl/exponential_backoff_jitter_top.sv]
// Capped exponential backoff with jitter. A next word (cmd 0) doubles the
// stored delay (or loads base_delay when it is zero), caps it at
// max(max_delay, base_delay), stores it and returns it with jitter taken from
// random_word mod (base_delay + min(delay, base_delay) + 1), kept non-negative.
// A clear word (cmd 1) zeroes the stored delay and returns nothing. A next
// word passes through the PREP, LOAD, DIV and OUT states; in DIV a bit-serial
// modulo unit retires one dividend bit per cycle. No new word is taken until
// the result has been accepted. Write registers only while idle.
module exponential_backoff_jitter_top import ebj_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [DELAY_BITS-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [RND_BITS-1:0]   random_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_BITS-1:0]   delay_out
);

	ebj_state_t state_q, state_nxt;

	logic [DELAY_BITS-1:0] base_q;
	logic [DELAY_BITS-1:0] max_q;
	logic [DELAY_BITS-1:0] last_q;
	logic [DELAY_BITS-1:0] b_q;
	logic [DELAY_BITS-1:0] lo_q;
	logic [RND_BITS-1:0]   rnd_q;
	logic [OUT_BITS-1:0]   delay_out_q;

	logic                  in_acc;
	logic [DELAY_BITS-1:0] cap;
	logic [DELAY_BITS:0]   dbl;
	logic [DELAY_BITS-1:0] b_nxt;
	logic [DVS_BITS-1:0]   divisor;
	logic [DVS_BITS-1:0]   remainder;
	ebj_mod_ctl_t          mod_ctl;
	ebj_mod_sts_t          mod_sts;

	assign in_acc = in_valid && !in_stall;

	always_comb begin
		cap = (max_q < base_q) ? base_q : max_q;
		dbl = (last_q == '0) ? {1'b0, base_q} : {last_q, 1'b0};
		b_nxt = (dbl < {1'b0, cap}) ? dbl[DELAY_BITS-1:0] : cap;
		divisor = {1'b0, base_q} + {1'b0, lo_q} + DVS_BITS'(1);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_NEXT) begin
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: state_nxt = ST_LOAD;
			ST_LOAD: state_nxt = ST_DIV;
			ST_DIV: begin
				if (mod_sts.done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		out_valid     = (state_q == ST_OUT);
		mod_ctl.start = (state_q == ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= DELAY_BITS'(1);
			max_q   <= DELAY_BITS'(1);
			last_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BASE: base_q <= cfg_data;
					REG_MAX:  max_q  <= cfg_data;
					default:  ;
				endcase
			end
			if (in_acc && cmd == CMD_CLEAR) begin
				last_q <= '0;
			end else if (state_q == ST_PREP) begin
				last_q <= b_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rnd_q <= random_word;
		end
		if (state_q == ST_PREP) begin
			b_q  <= b_nxt;
			lo_q <= (b_nxt < base_q) ? b_nxt : base_q;
		end
		if (state_q == ST_DIV && mod_sts.done) begin
			delay_out_q <= {1'b0, b_q} - {1'b0, lo_q} + remainder;
		end
	end

	ebj_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mod_ctl),
		.dividend  (rnd_q),
		.divisor   (divisor),
		.sts       (mod_sts),
		.remainder (remainder)
	);

	assign delay_out = delay_out_q;

endmodule

[test/tb_exponential_backoff_jitter_top.sv]
`timescale 1ns / 100ps

module tb_exponential_backoff_jitter_top;
	import ebj_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int TOTAL_WORDS   = 950;
	localparam int QUIET_FROM    = 850;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct packed {
		bit                    is_reg;
		logic                  idx;
		logic                  c;
		logic [RND_BITS-1:0]   data;
		bit                    typed;
		logic [OUT_BITS-1:0]   want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [DELAY_BITS-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  cmd;
	logic [RND_BITS-1:0]   random_word;
	logic                  out_valid;
	logic                  out_stall;
	logic [OUT_BITS-1:0]   delay_out;

	logic [DELAY_BITS-1:0] base_ms;
	logic [DELAY_BITS-1:0] max_ms;
	logic [DELAY_BITS-1:0] held_ms;
	logic [OUT_BITS-1:0]   pending_delays [$];
	logic [OUT_BITS-1:0]   due_delay;
	int                    words_sent;
	int                    fail_count;
	int                    cycle_count;
	bit                    quiet;
	bit                    gappy;
	script_row_t           script [36];

	exponential_backoff_jitter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.random_word(random_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.delay_out  (delay_out)
	);

	always #1 clk = ~clk;

	// next delay: double or load base, cap, store, add jitter kept non-negative
	function automatic logic [OUT_BITS-1:0] backoff_next(input logic [RND_BITS-1:0] rnd);
		logic [OUT_BITS-1:0] cap;
		logic [OUT_BITS-1:0] grown;
		logic [OUT_BITS-1:0] capped;
		logic [OUT_BITS-1:0] lo;
		logic [OUT_BITS-1:0] span;
		cap = (max_ms < base_ms) ? {1'b0, base_ms} : {1'b0, max_ms};
		grown = (held_ms == '0) ? {1'b0, base_ms} : {held_ms, 1'b0};
		capped = (grown < cap) ? grown : cap;
		held_ms = capped[DELAY_BITS-1:0];
		lo = (capped < {1'b0, base_ms}) ? capped : {1'b0, base_ms};
		span = {1'b0, base_ms} + lo;
		return capped - lo + ({1'b0, rnd} % (span + 1'b1));
	endfunction

	function automatic script_row_t reg_row(input logic idx, input logic [DELAY_BITS-1:0] v);
		script_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.idx = idx;
		r.data = v;
		return r;
	endfunction

	function automatic script_row_t word_row(input logic c, input logic [RND_BITS-1:0] rnd);
		script_row_t r;
		r = '0;
		r.c = c;
		r.data = rnd;
		return r;
	endfunction

	function automatic script_row_t known_row(input logic [RND_BITS-1:0] rnd,
			input logic [OUT_BITS-1:0] want);
		script_row_t r;
		r = word_row(CMD_NEXT, rnd);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic logic [DELAY_BITS-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 1;
			2: return '1;
			3: return $urandom;
			4: return 32'h8000_0000;
			default: return $urandom_range(1, 1000);
		endcase
	endfunction

	function automatic logic [DELAY_BITS-1:0] pick_limit();
		case ($urandom_range(0, 3))
			0: return base_ms << $urandom_range(0, 12);
			1: return base_ms >> $urandom_range(1, 4);
			default: return pick_delay();
		endcase
	endfunction

	task automatic cfg_write(input logic idx, input logic [DELAY_BITS-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == REG_BASE) begin
			base_ms = v;
		end else begin
			max_ms = v;
		end
	endtask

	task automatic send_word(input logic c, input logic [RND_BITS-1:0] rnd, input bit typed,
			input logic [OUT_BITS-1:0] want);
		logic [OUT_BITS-1:0] calc;
		if (cfg_we) begin
			cfg_we <= 1'b0;
		end
		cmd <= c;
		random_word <= rnd;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		words_sent++;
		quiet = words_sent >= QUIET_FROM;
		if (c == CMD_CLEAR) begin
			held_ms = '0;
		end else begin
			calc = backoff_next(rnd);
			pending_delays.push_back(typed ? want : calc);
		end
	endtask

	// clear words leave no result, so wait out the block's latency too
	task automatic settle();
		in_valid <= 1'b0;
		if (cfg_we) begin
			cfg_we <= 1'b0;
		end
		while (pending_delays.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_delays.size() == 0) begin
				$display("%0t: delay_out expected none, actual %0d", $time, delay_out);
				fail_count++;
			end else begin
				due_delay = pending_delays.pop_front();
				if (delay_out !== due_delay) begin
					$display("%0t: delay_out expected %0d, actual %0d", $time, due_delay,
						delay_out);
					fail_count++;
				end
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24)) @(posedge clk);
			if (!quiet) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_NEXT;
		random_word = '0;
		base_ms = 1;
		max_ms = 1;
		held_ms = '0;
		words_sent = 0;
		fail_count = 0;
		cycle_count = 0;
		quiet = 1'b0;
		gappy = 1'b0;

		script = '{
			known_row(32'd0, 33'd0),
			known_row(32'd2, 33'd2),
			known_row(32'hFFFF_FFFF, 33'd0),
			word_row(CMD_CLEAR, 32'hFFFF_FFFF),
			// zero base and zero max: delay stays zero
			reg_row(REG_BASE, 32'd0),
			reg_row(REG_MAX, 32'd0),
			known_row(32'hFFFF_FFFF, 33'd0),
			known_row(32'd5, 33'd0),
			reg_row(REG_BASE, 32'hFFFF_FFFF),
			reg_row(REG_MAX, 32'hFFFF_FFFF),
			known_row(32'd0, 33'd0),
			known_row(32'hFFFF_FFFF, 33'h0_FFFF_FFFF),
			word_row(CMD_CLEAR, 32'd0),
			// max below base
			reg_row(REG_BASE, 32'd100),
			reg_row(REG_MAX, 32'd10),
			known_row(32'd0, 33'd0),
			known_row(32'd200, 33'd200),
			word_row(CMD_CLEAR, 32'd12345),
			reg_row(REG_BASE, 32'd10),
			reg_row(REG_MAX, 32'd1000),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			// base raised above the stored delay
			reg_row(REG_BASE, 32'd100),
			known_row(32'd140, 33'd140),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			reg_row(REG_BASE, 32'd3),
			reg_row(REG_MAX, 32'd3000),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_NEXT, $urandom),
			word_row(CMD_CLEAR, $urandom),
			word_row(CMD_NEXT, 32'h7FFF_FFFF)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				if (i == 0 || !script[i-1].is_reg) begin
					settle();
				end
				cfg_write(script[i].idx, script[i].data);
			end else begin
				send_word(script[i].c, script[i].data, script[i].typed, script[i].want);
			end
		end

		while (words_sent < TOTAL_WORDS) begin
			settle();
			case ($urandom_range(0, 3))
				0: begin
					cfg_write(REG_BASE, pick_delay());
				end
				1: begin
					cfg_write(REG_MAX, pick_limit());
				end
				default: begin
					cfg_write(REG_BASE, pick_delay());
					cfg_write(REG_MAX, pick_limit());
				end
			endcase
			gappy = $urandom_range(0, 2) != 0;
			repeat ($urandom_range(4, 40)) begin
				send_word(($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_NEXT, $urandom, 1'b0,
					'0);
				if (gappy && !quiet && $urandom_range(0, 2) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end

		settle();
		if (fail_count == 0 && pending_delays.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
